### src/utf8v_pkg.sv
// Shared types and byte constants for the UTF-8 stream validator.
// Used by utf8v_step and utf8_stream_validator; depends on nothing.
`default_nettype none

package utf8v_pkg;

   // Per-string tracking state, cleared after every verdict.
   typedef struct packed {
      logic [1:0] bytes_pending;
      logic [1:0] cont_position;
      logic [7:0] lead_held;
      logic [7:0] first_cont_held;
      logic       error_seen;
   } utf8v_state_type;

   localparam logic [7:0] ASCII_LIMIT   = 8'h80;
   localparam logic [7:0] MASK_E0       = 8'hE0;
   localparam logic [7:0] MASK_F0       = 8'hF0;
   localparam logic [7:0] MASK_F8       = 8'hF8;
   localparam logic [7:0] MASK_FE       = 8'hFE;
   localparam logic [7:0] MASK_C0       = 8'hC0;
   localparam logic [7:0] LEAD2_TAG     = 8'hC0;
   localparam logic [7:0] LEAD3_TAG     = 8'hE0;
   localparam logic [7:0] LEAD4_TAG     = 8'hF0;
   localparam logic [7:0] CONT_TAG      = 8'h80;
   localparam logic [7:0] OVERLONG2_TAG = 8'hC0;
   localparam logic [7:0] LEAD_E0       = 8'hE0;
   localparam logic [7:0] LEAD_ED       = 8'hED;
   localparam logic [7:0] LEAD_EF       = 8'hEF;
   localparam logic [7:0] LEAD_F0       = 8'hF0;
   localparam logic [7:0] LEAD_F4       = 8'hF4;
   localparam logic [7:0] CONT_8F       = 8'h8F;
   localparam logic [7:0] CONT_BF       = 8'hBF;
   localparam logic [7:0] CONT_BE       = 8'hBE;
   localparam logic [7:0] SURR_TAG      = 8'hA0;
   localparam logic [7:0] CONT_80       = 8'h80;

endpackage

`default_nettype wire

### src/utf8_stream_validator.sv
// UTF-8 stream validator, top level: input register, state, result register.
// Depends on utf8v_pkg and utf8v_step.
//
// Usage: the string arrives one byte per request on the req_ channel
// (req_byte_value, req_last_byte, req_empty_string). A request with
// req_last_byte set produces one result on the rsp_ channel, rsp_is_valid,
// telling whether the whole string was well-formed UTF-8. A request with
// req_empty_string set produces rsp_is_valid = 1 and drops any partial
// string. Other requests produce no result.
// Timing: a request is registered in the input register on acceptance;
// its state update and verdict are computed from that register, and the
// verdict is registered in the result register when the request advances.
// Throughput is one byte per cycle while req_stall is low.
// Stall: while rsp_stall holds a waiting verdict, bytes that produce no
// result still flow; a request that ends a string waits in the input
// register, and req_stall rises only then.
// Reset: synchronous, active high; clears all tracking state and both
// valid flags.
`default_nettype none

module utf8_stream_validator
   import utf8v_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_last_byte,
   input  wire logic       req_empty_string,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_is_valid
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            in_empty_ff;
   utf8v_state_type state_ff, state_in, step_state;
   logic            step_verdict;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_is_valid_ff;
   logic            accept, advance, ends_string, out_free, load_rsp;

   assign ends_string = in_last_ff | in_empty_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   // Bytes that produce no verdict never wait on the result side.
   assign advance     = in_valid_ff && (!ends_string || out_free);
   assign load_rsp    = advance && ends_string;
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;

   utf8v_step u_step (
      .state_i        (state_ff),
      .byte_value_i   (in_byte_ff),
      .last_byte_i    (in_last_ff),
      .empty_string_i (in_empty_ff),
      .state_o        (step_state),
      .verdict_o      (step_verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      state_in = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_byte_value;
         in_last_ff  <= req_last_byte;
         in_empty_ff <= req_empty_string;
      end
      if (load_rsp) begin
         rsp_is_valid_ff <= step_verdict;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

`ifndef ASSERT_OFF
   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> state_ff == '0)
      else $error("tracking state not cleared after a verdict");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, state_ff.bytes_pending} + {1'b0, state_ff.cont_position}) <= 3'd3)
      else $error("pending plus taken continuation bytes exceeds three");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_seen && !load_rsp |=> state_ff.error_seen)
      else $error("error flag dropped before the end of the string");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_is_valid_ff))
      else $error("waiting verdict overwritten while stalled");

   a_pending_verdict_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && ends_string && rsp_valid_ff && rsp_stall |-> req_stall && !advance)
      else $error("string end advanced into an occupied result register");
`endif

endmodule

`default_nettype wire

### src/utf8v_step.sv
// Combinational per-byte update of the validator state and the verdict.
// Depends on utf8v_pkg for the state type and byte constants.
`default_nettype none

module utf8v_step
   import utf8v_pkg::*;
(
   input  wire utf8v_state_type state_i,
   input  wire logic [7:0]      byte_value_i,
   input  wire logic            last_byte_i,
   input  wire logic            empty_string_i,
   output utf8v_state_type      state_o,
   output logic                 verdict_o
);

   utf8v_state_type work;

   always_comb begin
      work      = state_i;
      verdict_o = 1'b0;
      state_o   = state_i;
      if (empty_string_i) begin
         state_o   = '0;
         verdict_o = 1'b1;
      end else begin
         if (!work.error_seen) begin
            if (work.bytes_pending == 2'd0) begin
               work.lead_held       = byte_value_i;
               work.first_cont_held = '0;
               work.cont_position   = '0;
               if (byte_value_i < ASCII_LIMIT) begin
                  work.bytes_pending = 2'd0;
               end else if ((byte_value_i & MASK_E0) == LEAD2_TAG) begin
                  if ((byte_value_i & MASK_FE) == OVERLONG2_TAG) begin
                     work.error_seen = 1'b1;
                  end
                  work.bytes_pending = 2'd1;
               end else if ((byte_value_i & MASK_F0) == LEAD3_TAG) begin
                  work.bytes_pending = 2'd2;
               end else if ((byte_value_i & MASK_F8) == LEAD4_TAG) begin
                  if (byte_value_i > LEAD_F4) begin
                     work.error_seen = 1'b1;
                  end
                  work.bytes_pending = 2'd3;
               end else begin
                  work.error_seen = 1'b1;
               end
            end else if ((byte_value_i & MASK_C0) != CONT_TAG) begin
               work.error_seen = 1'b1;
            end else begin
               if (work.cont_position == 2'd0) begin
                  work.first_cont_held = byte_value_i;
                  // Range checks on the first continuation byte by lead.
                  if (work.lead_held == LEAD_E0 && (byte_value_i & MASK_E0) == CONT_80) begin
                     work.error_seen = 1'b1;
                  end
                  if (work.lead_held == LEAD_ED && (byte_value_i & MASK_E0) == SURR_TAG) begin
                     work.error_seen = 1'b1;
                  end
                  if (work.lead_held == LEAD_F0 && (byte_value_i & MASK_F0) == CONT_80) begin
                     work.error_seen = 1'b1;
                  end
                  if (work.lead_held == LEAD_F4 && byte_value_i > CONT_8F) begin
                     work.error_seen = 1'b1;
                  end
               end else if (work.cont_position == 2'd1) begin
                  // Catches the noncharacters U+FFFE and U+FFFF.
                  if (work.lead_held == LEAD_EF && work.first_cont_held == CONT_BF &&
                      (byte_value_i & MASK_FE) == CONT_BE) begin
                     work.error_seen = 1'b1;
                  end
               end
               work.cont_position = work.cont_position + 2'd1;
               work.bytes_pending = work.bytes_pending - 2'd1;
            end
         end
         verdict_o = !work.error_seen && (work.bytes_pending == 2'd0);
         state_o   = last_byte_i ? '0 : work;
      end
   end

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for utf8_stream_validator: it sends strings byte by byte
// and compares each verdict with a built-in UTF-8 tracker.
// Depends on utf8v_pkg and the validator RTL.
`timescale 1ns / 100ps

module testbench;
   import utf8v_pkg::*;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte_value;
   logic       req_last_byte;
   logic       req_empty_string;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_valid;

   // Tracker state of the string in flight, mirrored from the block's behavior.
   logic [1:0] seq_remaining;
   logic [1:0] seq_taken;
   logic [7:0] seq_lead;
   logic [7:0] seq_second;
   logic       string_bad;

   logic       expected_verdicts[$];
   logic [7:0] text_bytes[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;

   utf8_stream_validator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_value(req_byte_value),
      .req_last_byte(req_last_byte),
      .req_empty_string(req_empty_string),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_valid(rsp_is_valid)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   task automatic clear_tracker();
      seq_remaining = 2'd0;
      seq_taken = 2'd0;
      seq_lead = 8'h00;
      seq_second = 8'h00;
      string_bad = 1'b0;
   endtask

   // Advances the tracker by one accepted request and queues the verdict it causes.
   task automatic track_utf8_request(input logic [7:0] b, input logic last,
                                     input logic empty);
      if (empty) begin
         clear_tracker();
         expected_verdicts.push_back(1'b1);
         return;
      end
      if (!string_bad) begin
         if (seq_remaining == 2'd0) begin
            seq_lead = b;
            seq_second = 8'h00;
            seq_taken = 2'd0;
            if (b < ASCII_LIMIT) begin
               seq_remaining = 2'd0;
            end else if ((b & MASK_E0) == LEAD2_TAG) begin
               if ((b & MASK_FE) == OVERLONG2_TAG) string_bad = 1'b1;
               seq_remaining = 2'd1;
            end else if ((b & MASK_F0) == LEAD3_TAG) begin
               seq_remaining = 2'd2;
            end else if ((b & MASK_F8) == LEAD4_TAG) begin
               if (b > LEAD_F4) string_bad = 1'b1;
               seq_remaining = 2'd3;
            end else begin
               string_bad = 1'b1;
            end
         end else if ((b & MASK_C0) != CONT_TAG) begin
            string_bad = 1'b1;
         end else begin
            if (seq_taken == 2'd0) begin
               seq_second = b;
               if (seq_lead == LEAD_E0 && (b & MASK_E0) == CONT_80) string_bad = 1'b1;
               if (seq_lead == LEAD_ED && (b & MASK_E0) == SURR_TAG) string_bad = 1'b1;
               if (seq_lead == LEAD_F0 && (b & MASK_F0) == CONT_80) string_bad = 1'b1;
               if (seq_lead == LEAD_F4 && b > CONT_8F) string_bad = 1'b1;
            end else if (seq_taken == 2'd1) begin
               if (seq_lead == LEAD_EF && seq_second == CONT_BF &&
                   (b & MASK_FE) == CONT_BE) string_bad = 1'b1;
            end
            seq_taken = seq_taken + 2'd1;
            seq_remaining = seq_remaining - 2'd1;
         end
      end
      if (last) begin
         expected_verdicts.push_back(!string_bad && seq_remaining == 2'd0);
         clear_tracker();
      end
   endtask

   // Presents one request after a random idle gap and holds it until accepted.
   task automatic send_request(input logic [7:0] b, input logic last, input logic empty);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_last_byte <= last;
      req_empty_string <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_utf8_request(b, last, empty);
   endtask

   // Sends a string of up to four bytes, most significant byte first.
   task automatic send_short_string(input logic [31:0] seq, input int len);
      int i;
      for (i = len - 1; i >= 0; i--) send_request(seq[8 * i +: 8], i == 0, 1'b0);
   endtask

   function automatic logic [7:0] pick_cont_byte();
      logic [7:0] edges[7] = '{8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBE, 8'hBF};
      if ($urandom_range(3) == 0) return edges[$urandom_range(6)];
      return {2'b10, 6'($urandom)};
   endfunction

   // Appends one code point; dirty strings also draw stray and invalid bytes.
   task automatic add_code_point(input logic clean);
      int kind;
      logic [7:0] lead;
      kind = clean ? $urandom_range(6) : $urandom_range(9);
      case (kind)
         0, 1: begin
            text_bytes.push_back(8'($urandom_range(8'h7F)));
         end
         2: begin
            text_bytes.push_back(8'($urandom_range(8'hDF, 8'hC0)));
            text_bytes.push_back(pick_cont_byte());
         end
         3, 4: begin
            case ($urandom_range(3))
               0: lead = LEAD_E0;
               1: lead = LEAD_ED;
               2: lead = LEAD_EF;
               default: lead = 8'($urandom_range(8'hEF, 8'hE0));
            endcase
            text_bytes.push_back(lead);
            if (lead == LEAD_EF && $urandom_range(2) == 0) begin
               text_bytes.push_back(CONT_BF);
               text_bytes.push_back(CONT_BE | 8'($urandom_range(1)));
            end else begin
               text_bytes.push_back(pick_cont_byte());
               text_bytes.push_back(pick_cont_byte());
            end
         end
         5, 6: begin
            case ($urandom_range(3))
               0: lead = LEAD_F0;
               1: lead = LEAD_F4;
               2: lead = 8'($urandom_range(8'hF3, 8'hF1));
               default: lead = 8'($urandom_range(8'hF7, 8'hF0));
            endcase
            text_bytes.push_back(lead);
            repeat (3) text_bytes.push_back(pick_cont_byte());
         end
         7: text_bytes.push_back(8'($urandom));
         8: text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
         default: text_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      endcase
   endtask

   task automatic test_directed();
      send_request(8'hFF, 1'b1, 1'b1);
      send_short_string(32'h00, 1);
      send_short_string(32'hFF, 1);
      send_short_string(32'h80, 1);
      send_short_string(32'hC080, 2);
      send_short_string(32'hE08080, 3);
      send_short_string(32'hEDA080, 3);
      send_short_string(32'hEFBFBF, 3);
      send_short_string(32'hF0808080, 4);
      send_short_string(32'hF4908080, 4);
      // The byte after a rejected lead is ignored until the end of the string.
      send_short_string(32'hF741, 2);
      send_short_string(32'hE282, 2);
      // An empty string flag drops the partial string and yields a valid verdict.
      send_request(8'hC2, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_random_strings(input int count, input int send_pct, input int recv_pct);
      int s;
      int i;
      int mode;
      logic clean;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (s = 0; s < count; s++) begin
         mode = $urandom_range(19);
         if (mode == 0) begin
            send_request(8'($urandom), 1'($urandom), 1'b1);
         end else begin
            text_bytes.delete();
            clean = mode < 15;
            repeat ($urandom_range(5, 1)) add_code_point(clean);
            if (!clean && text_bytes.size() > 1 && $urandom_range(2) == 0)
               void'(text_bytes.pop_back());
            for (i = 0; i < text_bytes.size(); i++)
               send_request(text_bytes[i], mode != 1 && i == text_bytes.size() - 1, 1'b0);
            if (mode == 1) send_request(8'($urandom), 1'($urandom), 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, got %0b", $time, rsp_is_valid);
            error_count++;
         end else if (rsp_is_valid !== expected_verdicts[0]) begin
            $display("%0t: verdict mismatch, expected %0b, got %0b",
                     $time, expected_verdicts[0], rsp_is_valid);
            error_count++;
            void'(expected_verdicts.pop_front());
         end else begin
            void'(expected_verdicts.pop_front());
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_value = 8'h00;
      req_last_byte = 1'b0;
      req_empty_string = 1'b0;
      clear_tracker();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      recv_idle_pct = 60;
      test_directed();
      test_random_strings(70, 24, 60);
      test_random_strings(70, 60, 24);
      test_random_strings(70, 0, 0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout with %0d verdicts outstanding", $time, expected_verdicts.size());
      $display("status: fail");
      $finish;
   end

endmodule
